@@ src/glt_pkg.sv @@
package glt_pkg;

  // Table geometry
  localparam int CODE_BITS   = 16;
  localparam int TABLE_DEPTH = 1 << CODE_BITS;
  localparam int GLYPH_COUNT = 256;
  localparam int GI_W        = 8;   // stored glyph index width
  localparam int DIM_W       = 9;   // grid and glyph size registers
  localparam int PIX_W       = 16;  // pixel coordinates
  localparam int IDX_W       = 18;  // 8x9 product plus an 8-bit add
  localparam int RUN_W       = 9;

  // Port widths
  localparam int ACT_W      = 3;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Actions
  localparam logic [ACT_W-1:0] ACT_MAP_CELL   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MAP_RUN    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MAP_DIRECT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LOOKUP     = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GH     = 3'd4;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [CODE_BITS-1:0] addr;
    logic [GI_W-1:0]      wdata;
  } ram_req_t;

  typedef struct packed {
    logic             start;
    logic [GI_W-1:0]  dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [GI_W-1:0] quot;
    logic [GI_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ src/glt_table.sv @@
module glt_table import glt_pkg::*; (
  input  logic            clk,
  input  ram_req_t        req,
  output logic [GI_W-1:0] rdata
);

  logic [GI_W-1:0] mem [TABLE_DEPTH];
  logic [GI_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/glt_div.sv @@
module glt_div import glt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEPS = GI_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [GI_W-1:0]  quo_r;
  logic [DIM_W-1:0] rem_r;
  logic [DIM_W-1:0] divisor_r;

  logic [DIM_W:0]   trial;
  logic             ge;
  logic [DIM_W-1:0] rem_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[GI_W-1]};
    ge      = trial >= {1'b0, divisor_r};
    rem_nxt = ge ? DIM_W'(trial - {1'b0, divisor_r}) : trial[DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r     <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[GI_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r[GI_W-1:0];

endmodule

@@ src/glyph_map_tile_lookup.sv @@
// Glyph map tile lookup. Keeps a 64K-entry table from character code to
// 8-bit glyph index in a single-port-write, registered-read memory, and
// turns a stored index back into the glyph's pixel rectangle in the atlas.
// After reset the table is swept to zero, one entry per cycle, during which
// no item is accepted; configuration writes are taken at any time but are
// meant only while the block is idle. Items are worked one at a time by a
// sequencer around the table: a single-code or direct map makes at most one
// table write, a run writes up to N codes (one table write per cycle), a
// clear repeats the zeroing sweep, and a lookup does the memory read, then
// the 8-step bit-serial divider that splits the index into column and row.
// One result item comes out per input item through an output register, so
// a new item can start while the last result waits to be taken.
module glyph_map_tile_lookup import glt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // code[15:0], cell_column[23:16], cell_row[31:24], run_length[40:32],
  // direct_glyph[48:41], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[2:0]
  input  logic [ACT_W-1:0]      in_tuser,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // glyph_index[7:0], rect_left[23:8], rect_top[39:24], rect_width[48:40],
  // rect_height[57:49], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[0]
  output logic [0:0]            out_tuser,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_EXEC  = 8'b00000100,
    ST_RUN   = 8'b00001000,
    ST_LREAD = 8'b00010000,
    ST_LDIV  = 8'b00100000,
    ST_LMUL  = 8'b01000000,
    ST_DONE  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic             col_major_r;
  logic [DIM_W-1:0] grid_cols_r;
  logic [DIM_W-1:0] grid_rows_r;
  logic [DIM_W-1:0] glyph_w_r;
  logic [DIM_W-1:0] glyph_h_r;

  // item being worked
  logic [ACT_W-1:0]     act_r;
  logic [CODE_BITS-1:0] code_r;
  logic [7:0]           col_r;
  logic [7:0]           row_r;
  logic [RUN_W-1:0]     run_cnt_r;
  logic [GI_W-1:0]      direct_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CODE_BITS-1:0] clr_addr_r;
  logic                 clr_cmd_r;

  // result
  logic             st_r;
  logic [GI_W-1:0]  gi_r;
  logic [7:0]       c_r;
  logic [7:0]       r_r;
  logic [PIX_W-1:0] left_r;
  logic [PIX_W-1:0] top_r;
  logic [DIM_W-1:0] rw_r;
  logic [DIM_W-1:0] rh_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  logic             in_accept;
  logic             out_load;
  logic [7:0]       mul_a;
  logic [DIM_W-1:0] mul_b;
  logic [7:0]       add_c;
  logic [16:0]      cell_prod;
  logic [IDX_W-1:0] idx_cell;
  logic [DIM_W-1:0] divisor;
  logic [16:0]      left_prod;
  logic [16:0]      top_prod;
  logic             run_stop;

  ram_req_t        ram_req;
  logic [GI_W-1:0] ram_rdata;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  glt_table u_table (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  glt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // cell to index: one 8x9 multiply and an add
  always_comb begin
    mul_a     = col_major_r ? col_r : row_r;
    mul_b     = col_major_r ? grid_rows_r : grid_cols_r;
    add_c     = col_major_r ? row_r : col_r;
    cell_prod = mul_a * mul_b;
    idx_cell  = IDX_W'(cell_prod) + IDX_W'(add_c);
    divisor   = col_major_r ? grid_rows_r : grid_cols_r;
    left_prod = c_r * glyph_w_r;
    top_prod  = r_r * glyph_h_r;
    run_stop  = (run_cnt_r == '0) || (idx_r >= IDX_W'(GLYPH_COUNT));
  end

  always_comb begin
    ram_req       = '0;
    ram_req.addr  = code_r;
    case (state_r)
      ST_CLEAR: begin
        ram_req.we   = 1'b1;
        ram_req.addr = clr_addr_r;
      end
      ST_EXEC: begin
        case (act_r)
          ACT_MAP_CELL: begin
            ram_req.we    = idx_cell < IDX_W'(GLYPH_COUNT);
            ram_req.wdata = idx_cell[GI_W-1:0];
          end
          ACT_MAP_DIRECT: begin
            ram_req.we    = {1'b0, direct_r} < (GI_W+1)'(GLYPH_COUNT);
            ram_req.wdata = direct_r;
          end
          ACT_LOOKUP: ram_req.re = 1'b1;
          default: ;
        endcase
      end
      ST_RUN: begin
        ram_req.we    = !run_stop;
        ram_req.wdata = idx_r[GI_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = (state_r == ST_LREAD);
    div_req.dividend = ram_rdata;
    div_req.divisor  = divisor;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) begin
          state_nxt = clr_cmd_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: if (in_accept) state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (act_r)
          ACT_MAP_RUN: state_nxt = ST_RUN;
          ACT_CLEAR:   state_nxt = ST_CLEAR;
          ACT_LOOKUP:  state_nxt = ST_LREAD;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_RUN:   if (run_stop) state_nxt = ST_DONE;
      ST_LREAD: state_nxt = ST_LDIV;
      ST_LDIV:  if (div_rsp.done) state_nxt = ST_LMUL;
      ST_LMUL:  state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_cmd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) clr_cmd_r <= 1'b0;
      end
      if (state_r == ST_EXEC && act_r == ACT_CLEAR) begin
        clr_cmd_r  <= 1'b1;
        clr_addr_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_major_r <= 1'b0;
      grid_cols_r <= DIM_W'(16);
      grid_rows_r <= DIM_W'(16);
      glyph_w_r   <= DIM_W'(8);
      glyph_h_r   <= DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LAYOUT: col_major_r <= cfg_data[0];
        CFG_COLS:   grid_cols_r <= cfg_data;
        CFG_ROWS:   grid_rows_r <= cfg_data;
        CFG_GW:     glyph_w_r   <= cfg_data;
        CFG_GH:     glyph_h_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          act_r     <= in_tuser;
          code_r    <= in_tdata[CODE_BITS-1:0];
          col_r     <= in_tdata[23:16];
          row_r     <= in_tdata[31:24];
          run_cnt_r <= in_tdata[40:32];
          direct_r  <= in_tdata[48:41];
          st_r      <= 1'b0;
          gi_r      <= '0;
          left_r    <= '0;
          top_r     <= '0;
          rw_r      <= '0;
          rh_r      <= '0;
        end
      end
      ST_EXEC: begin
        case (act_r)
          ACT_MAP_CELL:   st_r  <= idx_cell >= IDX_W'(GLYPH_COUNT);
          ACT_MAP_RUN:    idx_r <= idx_cell;
          ACT_MAP_DIRECT: st_r  <= {1'b0, direct_r} >= (GI_W+1)'(GLYPH_COUNT);
          default: ;
        endcase
      end
      ST_RUN: begin
        if (run_cnt_r != '0) begin
          if (idx_r >= IDX_W'(GLYPH_COUNT)) begin
            st_r <= 1'b1;
          end else begin
            code_r    <= code_r + 1'b1;
            idx_r     <= idx_r + 1'b1;
            run_cnt_r <= run_cnt_r - 1'b1;
          end
        end
      end
      ST_LREAD: gi_r <= ram_rdata;
      ST_LDIV: begin
        if (div_rsp.done) begin
          // a zero divisor maps every index to the top-left cell
          if (divisor == '0) begin
            c_r <= '0;
            r_r <= '0;
          end else if (col_major_r) begin
            c_r <= div_rsp.quot;
            r_r <= div_rsp.rem;
          end else begin
            c_r <= div_rsp.rem;
            r_r <= div_rsp.quot;
          end
        end
      end
      ST_LMUL: begin
        left_r <= left_prod[PIX_W-1:0];
        top_r  <= top_prod[PIX_W-1:0];
        rw_r   <= glyph_w_r;
        rh_r   <= glyph_h_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'b0, rh_r, rw_r, top_r, left_r, gi_r};
      out_user_r <= st_r;
    end
  end

endmodule

@@ tb/glyph_rect_checker.sv @@
`timescale 1ns / 1ps

module glyph_rect_checker import glt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // code[15:0], cell_column[23:16], cell_row[31:24], run_length[40:32],
  // direct_glyph[48:41], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[2:0]
  input  logic [ACT_W-1:0]      in_tuser,

  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // glyph_index[7:0], rect_left[23:8], rect_top[39:24], rect_width[48:40],
  // rect_height[57:49], zero pad
  input  logic [OUT_DATA_W-1:0] out_tdata,
  // status[0]
  input  logic [0:0]            out_tuser,

  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  output int                    fail_count,
  output int                    pending,
  output int                    n_results,
  output int                    n_lookups,
  output int                    n_flagged,
  output int                    n_blocked
);

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [15:0]          code;
    logic [7:0]           col;
    logic [7:0]           row;
    logic [RUN_W-1:0]     run_len;
    logic [GI_W-1:0]      direct;
  } glyph_req_t;

  typedef struct packed {
    logic                 status;
    logic [GI_W-1:0]      glyph;
    logic [PIX_W-1:0]     left;
    logic [PIX_W-1:0]     top;
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
  } glyph_rect_t;

  logic [GI_W-1:0]  code_glyph [TABLE_DEPTH];
  logic             col_major;
  logic [DIM_W-1:0] grid_cols;
  logic [DIM_W-1:0] grid_rows;
  logic [DIM_W-1:0] cell_w;
  logic [DIM_W-1:0] cell_h;

  glyph_rect_t expected_rects [$];
  glyph_req_t  req;
  glyph_rect_t exp_rect;

  initial begin
    fail_count = 0;
    pending    = 0;
    n_results  = 0;
    n_lookups  = 0;
    n_flagged  = 0;
    n_blocked  = 0;
  end

  function automatic void wipe_table();
    foreach (code_glyph[i]) code_glyph[i] = '0;
  endfunction

  function automatic glyph_rect_t predict_glyph_rect(glyph_req_t rq);
    glyph_rect_t res;
    int unsigned idx;
    int unsigned c;
    int unsigned r;
    int unsigned n;
    logic [15:0] code;
    res  = '0;
    code = rq.code;
    if (col_major) idx = int'(rq.col) * int'(grid_rows) + int'(rq.row);
    else           idx = int'(rq.row) * int'(grid_cols) + int'(rq.col);
    case (rq.action)
      ACT_MAP_CELL: begin
        if (idx >= GLYPH_COUNT) res.status = 1'b1;
        else code_glyph[code] = GI_W'(idx);
      end
      ACT_MAP_RUN: begin
        // stops at the first index past the atlas; earlier codes stay written
        n = 0;
        while (n < rq.run_len && !res.status) begin
          if (idx >= GLYPH_COUNT) begin
            res.status = 1'b1;
          end else begin
            code_glyph[code] = GI_W'(idx);
            code = code + 16'd1;
            idx++;
            n++;
          end
        end
      end
      ACT_MAP_DIRECT: begin
        if (int'(rq.direct) >= GLYPH_COUNT) res.status = 1'b1;
        else code_glyph[code] = rq.direct;
      end
      ACT_CLEAR: wipe_table();
      ACT_LOOKUP: begin
        res.glyph = code_glyph[code];
        c = 0;
        r = 0;
        // zero divisor leaves the cell at column 0, row 0
        if (col_major) begin
          if (grid_rows != 0) begin
            c = int'(res.glyph) / int'(grid_rows);
            r = int'(res.glyph) % int'(grid_rows);
          end
        end else if (grid_cols != 0) begin
          c = int'(res.glyph) % int'(grid_cols);
          r = int'(res.glyph) / int'(grid_cols);
        end
        res.left   = PIX_W'(c * int'(cell_w));
        res.top    = PIX_W'(r * int'(cell_h));
        res.width  = cell_w;
        res.height = cell_h;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      col_major = 1'b0;
      grid_cols = 9'd16;
      grid_rows = 9'd16;
      cell_w    = 9'd8;
      cell_h    = 9'd8;
      wipe_table();
      expected_rects.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LAYOUT: col_major = cfg_data[0];
          CFG_COLS:   grid_cols = cfg_data;
          CFG_ROWS:   grid_rows = cfg_data;
          CFG_GW:     cell_w    = cfg_data;
          CFG_GH:     cell_h    = cfg_data;
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        if (expected_rects.size() == 0) begin
          $error("result item arrived with no expectation pending");
          fail_count++;
        end else begin
          exp_rect = expected_rects.pop_front();
          n_results++;
          check_field("status",      32'(exp_rect.status), 32'(out_tuser[0]));
          check_field("glyph_index", 32'(exp_rect.glyph),  32'(out_tdata[7:0]));
          check_field("rect_left",   32'(exp_rect.left),   32'(out_tdata[23:8]));
          check_field("rect_top",    32'(exp_rect.top),    32'(out_tdata[39:24]));
          check_field("rect_width",  32'(exp_rect.width),  32'(out_tdata[48:40]));
          check_field("rect_height", 32'(exp_rect.height), 32'(out_tdata[57:49]));
        end
      end

      if (in_tvalid && in_tready) begin
        req = {in_tuser, in_tdata[15:0], in_tdata[23:16], in_tdata[31:24],
               in_tdata[40:32], in_tdata[48:41]};
        exp_rect = predict_glyph_rect(req);
        expected_rects.push_back(exp_rect);
        if (req.action == ACT_LOOKUP) n_lookups++;
        if (exp_rect.status) n_flagged++;
      end

      if (in_tvalid && !in_tready && out_tvalid && !out_tready) n_blocked++;
      pending = expected_rects.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import glt_pkg::*;

  localparam logic [ACT_W-1:0] ACT_LAST = 3'd7;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 24;
  // covers the reset sweep and a clear several times over
  localparam int WATCHDOG_LIMIT  = 300000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [ACT_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, n_results, n_lookups, n_flagged, n_blocked;

  bit tx_idle_en;
  bit rx_idle_en;
  int hold_req = 0;
  int hold_ack;
  int stall_left;
  int idle_cycles = 0;
  int cur_col_major;
  int cur_cols;
  int cur_rows;
  bit [15:0] recent_codes [$];

  glyph_map_tile_lookup u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  glyph_rect_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_results  (n_results),
    .n_lookups  (n_lookups),
    .n_flagged  (n_flagged),
    .n_blocked  (n_blocked)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(16, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [15:0] code,
                           input logic [7:0] col, input logic [7:0] row,
                           input logic [RUN_W-1:0] run_len, input logic [GI_W-1:0] direct);
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_DATA_W'({direct, run_len, row, col, code});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [ACT_W-1:0] act;
    logic [15:0]      code;
    logic [7:0]       col;
    logic [7:0]       row;
    logic [7:0]       direct;
    logic [RUN_W-1:0] run_len;
    int               pick;
    int               idx;
    pick    = $urandom_range(0, 399);
    col     = 8'($urandom);
    row     = 8'($urandom);
    direct  = 8'($urandom);
    run_len = RUN_W'($urandom);
    if (pick == 0)       act = ACT_CLEAR;
    else if (pick < 8)   act = ACT_W'($urandom_range(int'(ACT_LOOKUP) + 1, int'(ACT_LAST)));
    else if (pick < 100) act = ACT_MAP_CELL;
    else if (pick < 160) act = ACT_MAP_RUN;
    else if (pick < 200) act = ACT_MAP_DIRECT;
    else                 act = ACT_LOOKUP;

    // lookups mostly hit codes that were mapped recently
    if (act == ACT_LOOKUP && recent_codes.size() > 0 && $urandom_range(0, 3) != 0) begin
      code = recent_codes[$urandom_range(0, recent_codes.size() - 1)];
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: code = 16'($urandom_range(0, 63));
        4:          code = 16'hFFF0 | 16'($urandom_range(0, 15));
        default:    code = 16'($urandom);
      endcase
    end

    if ((act == ACT_MAP_CELL || act == ACT_MAP_RUN) && $urandom_range(0, 9) != 0) begin
      // pick a cell inside the atlas for the current layout
      idx = $urandom_range(0, 255);
      if (cur_col_major != 0) begin
        if (cur_rows != 0) begin
          col = 8'(idx / cur_rows);
          row = 8'(idx % cur_rows);
        end else begin
          row = 8'(idx);
        end
      end else if (cur_cols != 0) begin
        row = 8'(idx / cur_cols);
        col = 8'(idx % cur_cols);
      end else begin
        col = 8'(idx);
      end
    end

    if (act == ACT_MAP_RUN) begin
      case ($urandom_range(0, 19))
        0:       run_len = '0;
        1:       run_len = RUN_W'($urandom_range(17, 256));
        2:       run_len = RUN_W'($urandom_range(257, 511));
        default: run_len = RUN_W'($urandom_range(1, 16));
      endcase
    end

    if (act == ACT_MAP_CELL || act == ACT_MAP_RUN || act == ACT_MAP_DIRECT) begin
      recent_codes.push_back(code);
      if (act == ACT_MAP_RUN) recent_codes.push_back(code + 16'd1);
      while (recent_codes.size() > 48) void'(recent_codes.pop_front());
    end

    send_item(act, code, col, row, run_len, direct);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    hold_ack   = 0;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (hold_ack != hold_req) begin
        hold_ack++;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               idle_cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int lay, nc, nr, gw, gh;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b1;
    cur_col_major = 0;
    cur_cols      = 16;
    cur_rows      = 16;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed items at the reset layout: 16x16 cells of 8x8, row-major
    send_item(ACT_LOOKUP,     16'h0000, 8'd0,   8'd0,   9'd0,   8'd0);
    send_item(ACT_MAP_CELL,   16'hFFFF, 8'd15,  8'd15,  9'd0,   8'd0);
    send_item(ACT_LOOKUP,     16'hFFFF, 8'hFF,  8'hFF,  9'h1FF, 8'hFF);
    send_item(ACT_MAP_CELL,   16'h0010, 8'd0,   8'd16,  9'd0,   8'd0);
    send_item(ACT_MAP_CELL,   16'h5555, 8'hFF,  8'hFF,  9'd0,   8'd0);
    // run across the top of the code space
    send_item(ACT_MAP_RUN,    16'hFFFE, 8'd3,   8'd0,   9'd4,   8'd0);
    send_item(ACT_LOOKUP,     16'hFFFF, 8'd0,   8'd0,   9'd0,   8'd0);
    send_item(ACT_LOOKUP,     16'h0001, 8'd0,   8'd0,   9'd0,   8'd0);
    send_item(ACT_MAP_RUN,    16'h0040, 8'hFF,  8'hFF,  9'd0,   8'd0);
    // runs off the last cell after four codes
    send_item(ACT_MAP_RUN,    16'h0100, 8'd12,  8'd15,  9'd256, 8'd0);
    send_item(ACT_LOOKUP,     16'h0103, 8'd0,   8'd0,   9'd0,   8'd0);
    send_item(ACT_LOOKUP,     16'h0104, 8'd0,   8'd0,   9'd0,   8'd0);
    send_item(ACT_MAP_DIRECT, 16'h1234, 8'd0,   8'd0,   9'd0,   8'hFF);
    send_item(ACT_MAP_DIRECT, 16'hAAAA, 8'hFF,  8'hFF,  9'h1FF, 8'h00);
    send_item(ACT_LOOKUP,     16'h1234, 8'd0,   8'd0,   9'd0,   8'd0);
    for (int a = int'(ACT_LOOKUP) + 1; a <= int'(ACT_LAST); a++)
      send_item(ACT_W'(a), 16'hFFFF, 8'hFF, 8'hFF, 9'h1FF, 8'hFF);
    send_item(ACT_MAP_RUN,    16'h2000, 8'd0,   8'd0,   9'h1FF, 8'd0);
    send_item(ACT_LOOKUP,     16'h20FF, 8'd0,   8'd0,   9'd0,   8'd0);
    send_item(ACT_CLEAR,      16'h0000, 8'd0,   8'd0,   9'd0,   8'd0);
    send_item(ACT_LOOKUP,     16'hFFFF, 8'd0,   8'd0,   9'd0,   8'd0);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin lay = 0; nc = 16;  nr = 16;  gw = 8;   gh = 8;   end
        1: begin lay = 1; nc = 16;  nr = 16;  gw = 12;  gh = 16;  end
        2: begin lay = 0; nc = 1;   nr = 1;   gw = 1;   gh = 1;   end
        3: begin lay = 1; nc = 256; nr = 256; gw = 256; gh = 256; end
        4: begin lay = 0; nc = 256; nr = 1;   gw = 256; gh = 1;   end
        5: begin lay = 1; nc = 1;   nr = 256; gw = 3;   gh = 200; end
        // zero grid sizes and oversized cells
        7: begin lay = 0; nc = 0;   nr = 5;   gw = 511; gh = 511; end
        8: begin lay = 1; nc = 3;   nr = 0;   gw = 300; gh = 257; end
        default: begin
          lay = $urandom_range(0, 1);
          nc  = $urandom_range(1, 256);
          nr  = $urandom_range(1, 256);
          gw  = $urandom_range(1, 256);
          gh  = $urandom_range(1, 256);
        end
      endcase
      write_reg(CFG_LAYOUT, lay);
      write_reg(CFG_COLS,   nc);
      write_reg(CFG_ROWS,   nr);
      write_reg(CFG_GW,     gw);
      write_reg(CFG_GH,     gh);
      cur_col_major = lay;
      cur_cols      = nc;
      cur_rows      = nr;

      tx_idle_en = (ph % 3 != 2);
      rx_idle_en = tx_idle_en;
      if (ph == 1) begin
        // sender keeps pushing while the result side holds off
        hold_req++;
        tx_idle_en = 1'b0;
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
      drain();
    end

    $display("Covered %0d items over %0d register settings: %0d lookups, %0d flagged writes",
             n_results, NUM_PHASES + 1, n_lookups, n_flagged);
    $display("Input held back for %0d cycles behind a stalled result port", n_blocked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
